[sv/lsh_pkg.sv]
// Package for the log-scaled histogram engine: sizes, item and control types.
// Used by the top level, the controller and the datapath; depends on nothing else.
`default_nettype none

package lsh_pkg;

    localparam int NUM_BINS   = 1024;
    localparam int BIN_W      = 10;
    localparam int MARK_W     = 11;
    localparam int FRAC_BITS  = 8;
    localparam int SAMPLE_W   = 32;
    localparam int COUNT_W    = 32;
    localparam int SUBDIV_W   = 16;
    localparam int LOG_FRAC_W = 16;
    localparam int MAG_W      = 21;
    localparam int PROD_W     = 52;
    localparam int LG_W       = 21;
    localparam int PROD2_W    = 37;
    localparam int OFF_W      = 13;
    localparam int BINS_W     = 15;

    localparam logic [30:0] LOG10_2_Q32 = 31'd1292913987;
    localparam logic [SUBDIV_W-1:0] SUBDIV_RESET = 16'd2560;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic                func;
        logic [SAMPLE_W-1:0] sample;
        logic [BIN_W-1:0]    read_index;
    } in_item_t;

    typedef struct packed {
        logic               accepted;
        logic [BIN_W-1:0]   bin_index;
        logic [COUNT_W-1:0] bin_total;
        logic [MARK_W-1:0]  lowest_bin;
        logic [MARK_W-1:0]  bin_end;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NORM,
        ST_SQ,
        ST_BIT,
        ST_MAG,
        ST_MULA,
        ST_RND,
        ST_MULB,
        ST_BIN,
        ST_RD,
        ST_WR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic norm_step;
        logic sq_step;
        logic bit_step;
        logic mag_step;
        logic mula_step;
        logic rnd_step;
        logic mulb_step;
        logic bin_step;
        logic wr_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_read;
        logic is_zero;
        logic norm_done;
        logic bits_done;
        logic in_range;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[sv/log_scale_histogram_top.sv]
// Top level of the log-scaled histogram engine.
// Depends on lsh_pkg, lsh_ctrl, lsh_dp and, through the datapath, lsh_ram.
`default_nettype none

// The engine counts samples into logarithmically spaced bins: a nonzero
// sample lands in bin trunc(log10(sample / 256) * subdivisions) + NUM_BINS/2
// (the sample has FRAC_BITS = 8 fraction bits), and each item returns one
// result with the bin, its count and the used-bin marks. After reset the
// engine zeroes all NUM_BINS (1024) entries of the count memory and holds
// in_stall high meanwhile; the subdivisions register can be written during
// that time. Items are handled one at a time. For an add item, p is the
// position of the sample's leading one: the leading-one search shifts one
// place per cycle, and the 16-bit log2 fraction is then built one bit at a
// time by a single squaring multiplier, a square step and a bit step per bit.
// A finished result sits in the output register while the next item is
// accepted and worked on.
// The subdivisions register must only be written while no item is in flight.

module log_scale_histogram_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire lsh_pkg::in_item_t            in_item,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output lsh_pkg::out_item_t                out_item,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [lsh_pkg::SUBDIV_W-1:0] cfg_data
);

    import lsh_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Configuration is always taken at once.
    assign cfg_ready = 1'b1;

    lsh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    lsh_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .status    (status),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    // The count memory is never written by an item while it is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> in_stall)
        else $error("item taken during clearing pass");

    // A counted sample lies inside the reported marks.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.accepted) |->
            (out_item.lowest_bin <= 11'(out_item.bin_index)) &&
            (out_item.bin_end > 11'(out_item.bin_index)))
        else $error("counted bin outside marks");

    // A counted sample always leaves a nonzero count behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.accepted) |-> (out_item.bin_total != '0))
        else $error("counted bin shows zero total");

    // A result is only loaded when the output slot is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[sv/lsh_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the histogram count store.
`default_nettype none

module lsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/lsh_ctrl.sv]
// Controller state machine of the histogram engine.
// Depends on lsh_pkg; drives the datapath by commands and reads its status.
`default_nettype none

module lsh_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire lsh_pkg::status_t status,
    output lsh_pkg::cmd_t         cmd,
    output logic                  in_stall
);

    import lsh_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (status.clear_done) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                // The loaded item is decided here, in the cycle after it was taken.
                priority if (status.is_read)  state_next = ST_RD;
                else if (status.is_zero)      state_next = ST_OUT;
                else if (status.norm_done)    state_next = ST_SQ;
                else                          state_next = ST_NORM;
            end
            ST_SQ:   state_next = ST_BIT;
            ST_BIT:  state_next = status.bits_done ? ST_MAG : ST_SQ;
            ST_MAG:  state_next = ST_MULA;
            ST_MULA: state_next = ST_RND;
            ST_RND:  state_next = ST_MULB;
            ST_MULB: state_next = ST_BIN;
            ST_BIN:  state_next = ST_RD;
            ST_RD:   state_next = status.in_range ? ST_WR : ST_OUT;
            ST_WR:   state_next = ST_OUT;
            ST_OUT:  if (status.out_free) state_next = ST_IDLE;
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR: cmd.clr_step = 1'b1;
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            ST_NORM:
            begin
                cmd.norm_step = !status.is_read && !status.is_zero && !status.norm_done;
            end
            ST_SQ:   cmd.sq_step   = 1'b1;
            ST_BIT:  cmd.bit_step  = 1'b1;
            ST_MAG:  cmd.mag_step  = 1'b1;
            ST_MULA: cmd.mula_step = 1'b1;
            ST_RND:  cmd.rnd_step  = 1'b1;
            ST_MULB: cmd.mulb_step = 1'b1;
            ST_BIN:  cmd.bin_step  = 1'b1;
            ST_RD:   ;
            ST_WR:   cmd.wr_step   = 1'b1;
            ST_OUT:  cmd.out_load  = status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[sv/lsh_dp.sv]
// Datapath of the histogram engine: log2 by squaring, scaling, count update and readback.
// Depends on lsh_pkg and lsh_ram; steered by lsh_ctrl.
`default_nettype none

module lsh_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lsh_pkg::cmd_t                   cmd,
    input  wire lsh_pkg::in_item_t               in_item,
    input  wire logic                            cfg_valid,
    input  wire logic [lsh_pkg::SUBDIV_W-1:0]    cfg_data,
    input  wire logic                            out_stall,
    output lsh_pkg::status_t                     status,
    output logic                                 out_valid,
    output lsh_pkg::out_item_t                   out_item
);

    import lsh_pkg::*;

    logic [SUBDIV_W-1:0]   subdiv_reg;
    in_item_t              item_reg;
    logic [SAMPLE_W-1:0]   m_reg;
    logic [4:0]            p_reg;
    logic [63:0]           sq_reg;
    logic [LOG_FRAC_W-1:0] f_reg;
    logic [3:0]            bit_cnt_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic                  neg_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [LG_W-1:0]       lg_reg;
    logic [PROD2_W-1:0]    prod2_reg;
    logic [BIN_W-1:0]      bin_reg;
    logic                  range_reg;
    logic [BIN_W-1:0]      clr_cnt_reg;
    logic [MARK_W-1:0]     low_reg;
    logic [MARK_W-1:0]     high_reg;
    logic [MARK_W-1:0]     low_next;
    logic [MARK_W-1:0]     high_next;
    logic                  res_acc_reg;
    logic [BIN_W-1:0]      res_idx_reg;
    logic [COUNT_W-1:0]    res_total_reg;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;

    logic [32:0]           sq_shift;
    logic [MAG_W-1:0]      mag_next;
    logic                  neg_next;
    logic [PROD_W:0]       rnd_sum;
    logic [OFF_W-1:0]      off;
    logic signed [BINS_W-1:0] bin_s;
    logic [COUNT_W-1:0]    ram_rdata;
    logic [COUNT_W-1:0]    count_inc;
    logic                  ram_we;
    logic [BIN_W-1:0]      ram_waddr;
    logic [COUNT_W-1:0]    ram_wdata;
    logic [BIN_W-1:0]      ram_raddr;

    lsh_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_BINS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_we    = cmd.clr_step || (cmd.wr_step && !item_reg.func);
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : bin_reg;
    assign ram_wdata = cmd.clr_step ? '0 : count_inc;
    assign ram_raddr = item_reg.func ? item_reg.read_index : bin_reg;
    assign count_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;

    assign sq_shift = sq_reg[63:31];

    always_comb
    begin
        if (p_reg >= 5'(FRAC_BITS))
        begin
            mag_next = {5'(p_reg - 5'(FRAC_BITS)), f_reg};
            neg_next = 1'b0;
        end
        else
        begin
            mag_next = {5'(5'(FRAC_BITS) - p_reg), {LOG_FRAC_W{1'b0}}} - MAG_W'(f_reg);
            neg_next = 1'b1;
        end
    end

    assign rnd_sum = (PROD_W+1)'(prod_reg) + ((PROD_W+1)'(1) << 31);
    assign off     = prod2_reg[PROD2_W-1:24];
    assign bin_s   = neg_reg ? BINS_W'(NUM_BINS / 2) - BINS_W'(off)
                             : BINS_W'(NUM_BINS / 2) + BINS_W'(off);

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (MARK_W'(bin_reg) < low_reg)
        begin
            low_next = MARK_W'(bin_reg);
        end
        if (MARK_W'(bin_reg) >= high_reg)
        begin
            high_next = MARK_W'(bin_reg) + 1'b1;
        end
    end

    assign status.clear_done = (clr_cnt_reg == BIN_W'(NUM_BINS - 1));
    assign status.is_read    = (item_reg.func == FUNC_READ);
    assign status.is_zero    = (item_reg.sample == '0);
    assign status.norm_done  = m_reg[SAMPLE_W-1];
    assign status.bits_done  = (bit_cnt_reg == 4'd15);
    assign status.in_range   = range_reg || item_reg.func;
    assign status.out_free   = !out_valid_reg || !out_stall;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subdiv_reg    <= SUBDIV_RESET;
            clr_cnt_reg   <= '0;
            low_reg       <= MARK_W'(NUM_BINS);
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                subdiv_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.wr_step && !item_reg.func)
            begin
                low_reg  <= low_next;
                high_reg <= high_next;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            item_reg      <= in_item;
            m_reg         <= in_item.sample;
            p_reg         <= 5'd31;
            f_reg         <= '0;
            bit_cnt_reg   <= '0;
            range_reg     <= 1'b0;
            res_acc_reg   <= 1'b0;
            res_idx_reg   <= '0;
            res_total_reg <= '0;
        end
        if (cmd.norm_step)
        begin
            m_reg <= m_reg << 1;
            p_reg <= p_reg - 1'b1;
        end
        if (cmd.sq_step)
        begin
            sq_reg <= 64'(m_reg) * 64'(m_reg);
        end
        if (cmd.bit_step)
        begin
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
            f_reg       <= {f_reg[LOG_FRAC_W-2:0], sq_shift[32]};
            m_reg       <= sq_shift[32] ? sq_shift[32:1] : sq_shift[31:0];
        end
        if (cmd.mag_step)
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
        if (cmd.mula_step)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(LOG10_2_Q32);
        end
        if (cmd.rnd_step)
        begin
            lg_reg <= rnd_sum[32 +: LG_W];
        end
        if (cmd.mulb_step)
        begin
            prod2_reg <= PROD2_W'(lg_reg) * PROD2_W'(subdiv_reg);
        end
        if (cmd.bin_step)
        begin
            bin_reg   <= bin_s[BIN_W-1:0];
            range_reg <= !bin_s[BINS_W-1] && (bin_s < BINS_W'(NUM_BINS));
        end
        if (cmd.wr_step)
        begin
            if (item_reg.func)
            begin
                res_idx_reg   <= item_reg.read_index;
                res_total_reg <= ram_rdata;
            end
            else
            begin
                res_acc_reg   <= 1'b1;
                res_idx_reg   <= bin_reg;
                res_total_reg <= count_inc;
            end
        end
        if (cmd.out_load)
        begin
            out_item_reg.accepted   <= res_acc_reg;
            out_item_reg.bin_index  <= res_idx_reg;
            out_item_reg.bin_total  <= res_total_reg;
            out_item_reg.lowest_bin <= low_reg;
            out_item_reg.bin_end    <= high_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire
